// ===== src/p2y_pkg.sv =====
// Shared types and constants for the pixel to YUV packer.
// Holds the format codes, the byte command carried from front to back, and sizes.
// No dependencies.
package p2y_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Conversion coefficients
	localparam int COEF_YR     = 77;
	localparam int COEF_YG     = 150;
	localparam int COEF_YB     = 29;
	localparam int COEF_U      = 145;
	localparam int COEF_V      = 182;
	localparam int CHROMA_BIAS = 256 * 128;

	localparam logic FUNC_PIXEL   = 1'b0;
	localparam logic FUNC_PALETTE = 1'b1;

	localparam logic SRC_PALETTE = 1'b0;
	localparam logic SRC_RGB     = 1'b1;

	localparam logic REG_OUTPUT_FORMAT = 1'b0;
	localparam logic REG_SOURCE_MODE   = 1'b1;

	localparam logic [1:0] PLANE_LUMA    = 2'd0;
	localparam logic [1:0] PLANE_CHROMA1 = 2'd1;
	localparam logic [1:0] PLANE_CHROMA2 = 2'd2;

	typedef enum logic [2:0] {
		FMT_YV12 = 3'd0,
		FMT_IYUV = 3'd1,
		FMT_UYVY = 3'd2,
		FMT_YVYU = 3'd3,
		FMT_YUY2 = 3'd4
	} fmt_t;

	typedef enum logic [1:0] {
		SEL_Y    = 2'd0,
		SEL_U    = 2'd1,
		SEL_V    = 2'd2,
		SEL_HELD = 2'd3
	} sel_t;

	typedef enum logic [1:0] {
		HOLD_NONE = 2'd0,
		HOLD_U    = 2'd1,
		HOLD_V    = 2'd2
	} hold_t;

	// Up to three output bytes for one pixel
	typedef struct packed {
		logic [1:0]       count;
		sel_t [2:0]       sel;
		logic [2:0][1:0]  plane;
		logic [2:0]       skip;
		hold_t            hold;
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} entry_t;

endpackage

// ===== src/pixel_to_yuv_packer.sv =====
// Top level of the pixel to YUV packer: configuration registers and the
// front end, command queue and back end. Depends on p2y_pkg and all p2y modules.
//
//   port group      direction  handshake          payload
//   input items     in         in_valid/in_stall  func red green blue color_index
//                                                 line_end frame_end
//   output bytes    out        out_valid/out_stall data_byte plane skip_before last
//   configuration   in/out     APB psel/penable   paddr pwdata prdata
//
// One output byte per cycle while out_stall is low; a pixel gives 0 to 3 bytes on the output register
// (its byte count, none for an undefined format), a palette write gives no byte.
// Items cross four front stages (two conversion stages, palette RAM read) into a
// four-entry queue; the front keeps accepting while the queue has room.
// Reset clears parities, held chroma, queue and valids; palette contents are undefined
// until written. Output stall backs up the queue and then the input.
module pixel_to_yuv_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  color_index,
	input  logic        line_end,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_byte,
	output logic [1:0]  plane,
	output logic        skip_before,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] output_format_q;
	logic       source_mode_q;
	logic       cfg_write;

	logic            fifo_full;
	logic            push;
	p2y_pkg::entry_t push_data;
	logic            pop;
	logic            head_valid;
	p2y_pkg::entry_t head_data;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_format_q <= 3'd0;
			source_mode_q   <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[2])
				p2y_pkg::REG_OUTPUT_FORMAT: output_format_q <= pwdata[2:0];
				p2y_pkg::REG_SOURCE_MODE:   source_mode_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			p2y_pkg::REG_OUTPUT_FORMAT: prdata = {29'd0, output_format_q};
			p2y_pkg::REG_SOURCE_MODE:   prdata = {31'd0, source_mode_q};
			default:                    prdata = 32'd0;
		endcase
	end

	p2y_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.color_index   (color_index),
		.line_end      (line_end),
		.frame_end     (frame_end),
		.output_format (output_format_q),
		.source_mode   (source_mode_q),
		.fifo_full     (fifo_full),
		.push          (push),
		.push_data     (push_data)
	);

	p2y_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (fifo_full),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	p2y_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.plane       (plane),
		.skip_before (skip_before),
		.last        (last)
	);

endmodule

// ===== src/p2y_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the palette store. No dependencies.
module p2y_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/p2y_front.sv =====
// Front end: accepts items, classifies pixels into byte commands, converts RGB,
// keeps the palette and feeds the command queue. Depends on p2y_pkg, p2y_ram.
module p2y_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        color_index,
	input  logic              line_end,
	input  logic              frame_end,
	input  logic [2:0]        output_format,
	input  logic              source_mode,
	input  logic              fifo_full,
	output logic              push,
	output p2y_pkg::entry_t   push_data
);

	logic adv;
	logic accept;
	logic le_eff;
	p2y_pkg::fmt_t fmt;
	p2y_pkg::cmd_t cmd_in;

	logic col_odd_q;
	logic row_odd_q;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4;
	logic                  func_s1, func_s2, func_s3;
	p2y_pkg::cmd_t         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [7:0]            idx_s1, idx_s2, idx_s3;
	logic [7:0]            red_s1, green_s1, blue_s1;
	logic [7:0]            red_s2, blue_s2, luma_s2;
	logic [7:0]            y_s3, u_s3, v_s3;
	logic                  inrange_s3;
	logic [7:0]            y_s4, u_s4, v_s4;
	logic                  use_ram_s4;

	logic [15:0]           luma_sum;
	logic signed [8:0]     bdiff, rdiff;
	logic signed [17:0]    u_sum, v_sum;
	logic                  inrange_s2;

	logic                  ram_we, ram_re;
	logic [23:0]           ram_rdata;

	assign adv      = !(valid_s4 && fifo_full);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign le_eff   = line_end || frame_end;
	assign fmt      = p2y_pkg::fmt_t'(output_format);

	// Byte plan for one pixel from format and parity
	always_comb begin
		cmd_in          = '0;
		cmd_in.sel[0]   = p2y_pkg::SEL_Y;
		cmd_in.sel[1]   = p2y_pkg::SEL_Y;
		cmd_in.sel[2]   = p2y_pkg::SEL_Y;
		cmd_in.hold     = p2y_pkg::HOLD_NONE;
		cmd_in.plane[0] = p2y_pkg::PLANE_LUMA;
		cmd_in.plane[1] = p2y_pkg::PLANE_LUMA;
		cmd_in.plane[2] = p2y_pkg::PLANE_LUMA;
		case (fmt) inside
			p2y_pkg::FMT_YV12, p2y_pkg::FMT_IYUV: begin
				cmd_in.plane[1] = p2y_pkg::PLANE_CHROMA1;
				cmd_in.plane[2] = p2y_pkg::PLANE_CHROMA2;
				if (fmt == p2y_pkg::FMT_YV12) begin
					cmd_in.sel[1] = p2y_pkg::SEL_V;
					cmd_in.sel[2] = p2y_pkg::SEL_U;
				end else begin
					cmd_in.sel[1] = p2y_pkg::SEL_U;
					cmd_in.sel[2] = p2y_pkg::SEL_V;
				end
				cmd_in.count = (!col_odd_q && !row_odd_q) ? 2'd3 : 2'd1;
			end
			p2y_pkg::FMT_UYVY: begin
				if (!col_odd_q) begin
					cmd_in.sel[0] = p2y_pkg::SEL_U;
					cmd_in.sel[2] = p2y_pkg::SEL_V;
					cmd_in.count  = 2'd3;
				end else begin
					cmd_in.count  = 2'd1;
				end
			end
			p2y_pkg::FMT_YVYU, p2y_pkg::FMT_YUY2: begin
				if (!col_odd_q) begin
					if (fmt == p2y_pkg::FMT_YVYU) begin
						cmd_in.sel[1] = p2y_pkg::SEL_V;
						cmd_in.hold   = p2y_pkg::HOLD_U;
					end else begin
						cmd_in.sel[1] = p2y_pkg::SEL_U;
						cmd_in.hold   = p2y_pkg::HOLD_V;
					end
					// flush the held chroma at an odd line end
					cmd_in.sel[2]  = p2y_pkg::SEL_HELD;
					cmd_in.skip[2] = 1'b1;
					cmd_in.count   = le_eff ? 2'd3 : 2'd2;
				end else begin
					cmd_in.sel[1] = p2y_pkg::SEL_HELD;
					cmd_in.count  = 2'd2;
				end
			end
			default: begin
				cmd_in.count = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_odd_q <= 1'b0;
			row_odd_q <= 1'b0;
		end else if (accept && func == p2y_pkg::FUNC_PIXEL) begin
			if (le_eff) begin
				col_odd_q <= 1'b0;
				row_odd_q <= frame_end ? 1'b0 : !row_odd_q;
			end else begin
				col_odd_q <= !col_odd_q;
			end
		end
	end

	// Luma from stage 1, chroma from stage 2
	assign luma_sum = 16'(red_s1) * 16'(p2y_pkg::COEF_YR)
		+ 16'(green_s1) * 16'(p2y_pkg::COEF_YG)
		+ 16'(blue_s1) * 16'(p2y_pkg::COEF_YB);

	assign bdiff = $signed({1'b0, blue_s2}) - $signed({1'b0, luma_s2});
	assign rdiff = $signed({1'b0, red_s2}) - $signed({1'b0, luma_s2});
	assign u_sum = 18'(bdiff) * 18'(p2y_pkg::COEF_U) + 18'(p2y_pkg::CHROMA_BIAS);
	assign v_sum = 18'(rdiff) * 18'(p2y_pkg::COEF_V) + 18'(p2y_pkg::CHROMA_BIAS);

	assign inrange_s2 = {1'b0, idx_s2} < 9'(p2y_pkg::PAL_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 && func_s3 == p2y_pkg::FUNC_PIXEL && cmd_s3.count != 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1    <= func;
			cmd_s1     <= cmd_in;
			idx_s1     <= color_index;
			red_s1     <= red;
			green_s1   <= green;
			blue_s1    <= blue;

			func_s2    <= func_s1;
			cmd_s2     <= cmd_s1;
			idx_s2     <= idx_s1;
			red_s2     <= red_s1;
			blue_s2    <= blue_s1;
			luma_s2    <= luma_sum[15:8];

			func_s3    <= func_s2;
			cmd_s3     <= cmd_s2;
			idx_s3     <= idx_s2;
			y_s3       <= luma_s2;
			u_s3       <= u_sum[15:8];
			v_s3       <= v_sum[15:8];
			inrange_s3 <= inrange_s2;

			cmd_s4     <= cmd_s3;
			y_s4       <= y_s3;
			u_s4       <= u_s3;
			v_s4       <= v_s3;
			use_ram_s4 <= inrange_s3;
		end
	end

	// Palette writes and lookups meet at stage 3, so a lookup sees every earlier write
	assign ram_we = adv && valid_s3 && func_s3 == p2y_pkg::FUNC_PALETTE && inrange_s3;
	assign ram_re = adv && valid_s3 && func_s3 == p2y_pkg::FUNC_PIXEL;

	p2y_ram #(
		.WIDTH(24),
		.DEPTH(p2y_pkg::PAL_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s3[p2y_pkg::PAL_AW-1:0]),
		.wdata ({y_s3, u_s3, v_s3}),
		.re    (ram_re),
		.raddr (idx_s3[p2y_pkg::PAL_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign push = valid_s4 && !fifo_full;

	always_comb begin
		push_data     = '0;
		push_data.cmd = cmd_s4;
		if (source_mode == p2y_pkg::SRC_RGB) begin
			push_data.y = y_s4;
			push_data.u = u_s4;
			push_data.v = v_s4;
		end else if (use_ram_s4) begin
			push_data.y = ram_rdata[23:16];
			push_data.u = ram_rdata[15:8];
			push_data.v = ram_rdata[7:0];
		end
	end

endmodule

// ===== src/p2y_fifo.sv =====
// Short command queue between front and back ends.
// Depends on p2y_pkg.
module p2y_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  p2y_pkg::entry_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output p2y_pkg::entry_t head_data
);

	p2y_pkg::entry_t              mem_q [p2y_pkg::FIFO_DEPTH];
	logic [p2y_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [p2y_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [p2y_pkg::FIFO_CW-1:0]  count_q;

	assign full       = count_q == p2y_pkg::FIFO_CW'(p2y_pkg::FIFO_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/p2y_back.sv =====
// Back end: walks each queued command one byte per beat into the output register
// and keeps the held chroma byte for packed layouts. Depends on p2y_pkg.
module p2y_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  p2y_pkg::entry_t head_data,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      data_byte,
	output logic [1:0]      plane,
	output logic            skip_before,
	output logic            last
);

	p2y_pkg::cmd_t cmd;
	logic       load;
	logic       beat_last;
	logic [1:0] beat_q;
	logic [7:0] held_q;
	logic [7:0] hold_new;
	logic [7:0] held_eff;
	logic       hold_set;
	logic [7:0] byte_sel;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_plane_q;
	logic       out_skip_q;
	logic       out_last_q;

	assign cmd       = head_data.cmd;
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign beat_last = beat_q == (cmd.count - 2'd1);
	assign pop       = load && beat_last;
	assign hold_set  = beat_q == 2'd0 && cmd.hold != p2y_pkg::HOLD_NONE;

	always_comb begin
		case (cmd.hold)
			p2y_pkg::HOLD_U: hold_new = head_data.u;
			p2y_pkg::HOLD_V: hold_new = head_data.v;
			default:         hold_new = held_q;
		endcase
	end

	// the flush byte of an even pixel reads the value it just held
	assign held_eff = hold_set ? hold_new : held_q;

	always_comb begin
		case (cmd.sel[beat_q])
			p2y_pkg::SEL_Y:    byte_sel = head_data.y;
			p2y_pkg::SEL_U:    byte_sel = head_data.u;
			p2y_pkg::SEL_V:    byte_sel = head_data.v;
			p2y_pkg::SEL_HELD: byte_sel = held_eff;
			default:           byte_sel = head_data.y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= 2'd0;
			held_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q <= beat_last ? 2'd0 : beat_q + 2'd1;
				if (hold_set) begin
					held_q <= hold_new;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= byte_sel;
			out_plane_q <= cmd.plane[beat_q];
			out_skip_q  <= cmd.skip[beat_q];
			out_last_q  <= beat_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = out_byte_q;
	assign plane       = out_plane_q;
	assign skip_before = out_skip_q;
	assign last        = out_last_q;

	a_beat_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> beat_q < head_data.cmd.count)
		else $error("beat index beyond command length");

	a_held_only_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && beat_q == 2'd0) |=> held_q == $past(held_q))
		else $error("held chroma changed outside a first beat");

	a_last_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_last_q && out_valid_q)
		else $error("final beat of a command not marked last");

endmodule

// ===== sim/tb_pixel_to_yuv_packer.sv =====
// Self-checking testbench for pixel_to_yuv_packer: drives palette writes and pixel
// beats, predicts every output byte in a scoreboard class, and checks them in order.
// Depends on p2y_pkg and the pixel_to_yuv_packer RTL.
module tb_pixel_to_yuv_packer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 5;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD    = 120;
	localparam int RANDOM_ITEMS = 330;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		logic [7:0] data;
		logic [1:0] plane;
		logic       skip;
		logic       last;
	} yuv_byte_t;

	class yuv_scoreboard;
		yuv_byte_t  expected_bytes[$];
		logic [7:0] luma_tab[p2y_pkg::PAL_ENTRIES];
		logic [7:0] u_tab[p2y_pkg::PAL_ENTRIES];
		logic [7:0] v_tab[p2y_pkg::PAL_ENTRIES];
		logic [7:0] held;
		logic [2:0] fmt;
		logic       src;
		bit         col_odd;
		bit         row_odd;
		int         errors;
		int         bytes_checked;
		int         pixels;
		int         palette_writes;

		function new();
			held = 8'd0;
			fmt = p2y_pkg::FMT_YV12;
			src = p2y_pkg::SRC_PALETTE;
			col_odd = 1'b0;
			row_odd = 1'b0;
		endfunction

		function void set_config(input logic [2:0] f, input logic s);
			fmt = f;
			src = s;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// Chroma is a floor shift of a signed sum; its low byte is bits 15:8.
		function void rgb_to_yuv(input logic [7:0] r, g, b,
			output logic [7:0] y, u, v);
			int luma, cu, cv;
			luma = (p2y_pkg::COEF_YR * r + p2y_pkg::COEF_YG * g
				+ p2y_pkg::COEF_YB * b) >>> 8;
			cu = (int'(b) - luma) * p2y_pkg::COEF_U + p2y_pkg::CHROMA_BIAS;
			cv = (int'(r) - luma) * p2y_pkg::COEF_V + p2y_pkg::CHROMA_BIAS;
			y = luma[7:0];
			u = cu[15:8];
			v = cv[15:8];
		endfunction

		function void add_byte(input logic [7:0] d, input logic [1:0] p, input logic s);
			yuv_byte_t e;
			e.data = d;
			e.plane = p;
			e.skip = s;
			e.last = 1'b0;
			expected_bytes.push_back(e);
		endfunction

		function void note_item(input logic f, input logic [7:0] r, g, b, idx,
			input logic le, input logic fe);
			logic [7:0] y, u, v;
			int prior_count;
			bit lend;
			lend = le || fe;
			if (f == p2y_pkg::FUNC_PALETTE) begin
				rgb_to_yuv(r, g, b, y, u, v);
				luma_tab[idx] = y;
				u_tab[idx] = u;
				v_tab[idx] = v;
				palette_writes++;
				return;
			end
			pixels++;
			if (src == p2y_pkg::SRC_RGB) begin
				rgb_to_yuv(r, g, b, y, u, v);
			end else begin
				y = luma_tab[idx];
				u = u_tab[idx];
				v = v_tab[idx];
			end
			prior_count = expected_bytes.size();
			case (fmt)
				p2y_pkg::FMT_YV12, p2y_pkg::FMT_IYUV: begin
					add_byte(y, p2y_pkg::PLANE_LUMA, 1'b0);
					if (!col_odd && !row_odd) begin
						add_byte(fmt == p2y_pkg::FMT_YV12 ? v : u,
							p2y_pkg::PLANE_CHROMA1, 1'b0);
						add_byte(fmt == p2y_pkg::FMT_YV12 ? u : v,
							p2y_pkg::PLANE_CHROMA2, 1'b0);
					end
				end
				p2y_pkg::FMT_UYVY: begin
					if (!col_odd) begin
						add_byte(u, p2y_pkg::PLANE_LUMA, 1'b0);
						add_byte(y, p2y_pkg::PLANE_LUMA, 1'b0);
						add_byte(v, p2y_pkg::PLANE_LUMA, 1'b0);
					end else begin
						add_byte(y, p2y_pkg::PLANE_LUMA, 1'b0);
					end
				end
				p2y_pkg::FMT_YVYU, p2y_pkg::FMT_YUY2: begin
					add_byte(y, p2y_pkg::PLANE_LUMA, 1'b0);
					if (!col_odd) begin
						add_byte(fmt == p2y_pkg::FMT_YVYU ? v : u, p2y_pkg::PLANE_LUMA, 1'b0);
						held = (fmt == p2y_pkg::FMT_YVYU) ? u : v;
						// flush the held chroma, leaving the next luma slot empty
						if (lend)
							add_byte(held, p2y_pkg::PLANE_LUMA, 1'b1);
					end else begin
						add_byte(held, p2y_pkg::PLANE_LUMA, 1'b0);
					end
				end
				default: ;
			endcase
			if (expected_bytes.size() > prior_count)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
			if (lend) begin
				col_odd = 1'b0;
				row_odd = fe ? 1'b0 : !row_odd;
			end else begin
				col_odd = !col_odd;
			end
		endfunction

		function void check_byte(input logic [7:0] d, input logic [1:0] p,
			input logic s, input logic l);
			yuv_byte_t e;
			if (expected_bytes.size() == 0) begin
				$error("unexpected byte: data_byte %0h plane %0d", d, p);
				errors++;
				return;
			end
			e = expected_bytes.pop_front();
			bytes_checked++;
			if (e.data !== d) begin
				$error("data_byte: expected %0h, got %0h", e.data, d);
				errors++;
			end
			if (e.plane !== p) begin
				$error("plane: expected %0d, got %0d", e.plane, p);
				errors++;
			end
			if (e.skip !== s) begin
				$error("skip_before: expected %0b, got %0b", e.skip, s);
				errors++;
			end
			if (e.last !== l) begin
				$error("last: expected %0b, got %0b", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  color_index;
	logic        line_end;
	logic        frame_end;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  data_byte;
	logic [1:0]  plane;
	logic        skip_before;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	yuv_scoreboard sb = new();

	bit         tx_quiet;
	bit         rx_quiet;
	bit         long_hold_req;
	logic [2:0] cur_fmt;
	logic       cur_src;
	bit         pal_written[p2y_pkg::PAL_ENTRIES];
	int         pal_list[$];
	int         items_sent;
	int         mode_changes;
	int         cycle_count;

	pixel_to_yuv_packer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.color_index (color_index),
		.line_end    (line_end),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_byte   (data_byte),
		.plane       (plane),
		.skip_before (skip_before),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d bytes outstanding", cycle_count, sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(data_byte, plane, skip_before, last);
	end

	// Receiver: wait a drawn number of cycles before each beat, or hold off long on request.
	initial begin : receiver
		int hold_cycles;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				hold_cycles = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
			end
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Called at a clock edge; returns at the edge that accepts the beat with valid still high.
	task automatic send_item(input logic f, input logic [7:0] r, g, b, idx,
		input logic le, input logic fe);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		red         <= r;
		green       <= g;
		blue        <= b;
		color_index <= idx;
		line_end    <= le;
		frame_end   <= fe;
		do @(posedge clk); while (in_stall);
		sb.note_item(f, r, g, b, idx, le, fe);
		items_sent++;
	endtask

	task automatic write_palette(input logic [7:0] idx, input logic [7:0] r, g, b,
		input logic le, input logic fe);
		send_item(p2y_pkg::FUNC_PALETTE, r, g, b, idx, le, fe);
		if (!pal_written[idx]) begin
			pal_written[idx] = 1'b1;
			pal_list.push_back(idx);
		end
	endtask

	// Palette lookups only ever hit entries that were written.
	task automatic send_pixel(input logic le, input logic fe);
		logic [7:0] idx;
		if (cur_src == p2y_pkg::SRC_PALETTE)
			idx = 8'(pal_list[$urandom_range(0, pal_list.size() - 1)]);
		else
			idx = 8'($urandom_range(0, 255));
		send_item(p2y_pkg::FUNC_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), idx, le, fe);
	endtask

	task automatic send_frame(input int lines, input int max_width);
		int width;
		bit le, fe;
		for (int ln = 0; ln < lines; ln++) begin
			width = $urandom_range(1, max_width);
			for (int col = 0; col < width; col++) begin
				if ($urandom_range(0, 11) == 0)
					write_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				le = (col == width - 1);
				fe = le && (ln == lines - 1);
				// drop the line end on some frame ends, break some frames early
				if (fe && $urandom_range(0, 1))
					le = 1'b0;
				if (!fe && $urandom_range(0, 19) == 0)
					fe = 1'b1;
				send_pixel(le, fe);
			end
		end
	endtask

	// Setup phase, then access phase until pready, then idle with psel low so transfers never overlap.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Drain all expected bytes plus the pipeline depth, then reprogram both registers.
	task automatic set_mode(input logic [2:0] fmt, input logic src);
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		apb_write({p2y_pkg::REG_OUTPUT_FORMAT, 2'b00}, 32'(fmt));
		apb_write({p2y_pkg::REG_SOURCE_MODE, 2'b00}, 32'(src));
		sb.set_config(fmt, src);
		cur_fmt = fmt;
		cur_src = src;
		mode_changes++;
	endtask

	initial begin : stimulus
		logic [2:0] fmt;
		int phase;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = p2y_pkg::FUNC_PIXEL;
		red         = 8'd0;
		green       = 8'd0;
		blue        = 8'd0;
		color_index = 8'd0;
		line_end    = 1'b0;
		frame_end   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = 3'd0;
		pwdata      = 32'd0;
		tx_quiet    = 1'b0;
		rx_quiet    = 1'b0;
		long_hold_req = 1'b0;
		items_sent  = 0;
		mode_changes = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme colors, chroma wrap, ignored end marks on palette writes.
		set_mode(p2y_pkg::FMT_YV12, p2y_pkg::SRC_PALETTE);
		write_palette(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
		write_palette(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
		write_palette(8'd1, 8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
		write_palette(8'd2, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
		write_palette(8'd3, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd2, 1'b1, 1'b1);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd3, 1'b0, 1'b1);

		// Packed: odd line end flush, frame end without line end.
		set_mode(p2y_pkg::FMT_YUY2, p2y_pkg::SRC_RGB);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b1);

		// Odd column after a format change picks up the stale held chroma.
		set_mode(p2y_pkg::FMT_UYVY, p2y_pkg::SRC_RGB);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
		set_mode(p2y_pkg::FMT_YVYU, p2y_pkg::SRC_RGB);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd128, 8'd64, 8'd32, 8'd0, 1'b1, 1'b0);

		// Undefined format: no bytes, parities still move.
		set_mode(3'd7, p2y_pkg::SRC_PALETTE);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
		send_item(p2y_pkg::FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0, 1'b1);

		phase = 0;
		while (items_sent < RANDOM_ITEMS - 30) begin
			fmt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			if (phase == 3)
				fmt = p2y_pkg::FMT_UYVY;
			set_mode(fmt, 1'($urandom_range(0, 1)));
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 3) begin
				// back up the output so the front and the queue fill and stall input
				tx_quiet = 1'b1;
				long_hold_req = 1'b1;
				send_frame(4, 8);
			end
			repeat ($urandom_range(1, 6))
				write_palette(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			repeat ($urandom_range(1, 3))
				send_frame($urandom_range(1, 4), $urandom_range(1, 8));
			phase++;
		end
		set_mode(p2y_pkg::FMT_IYUV, p2y_pkg::SRC_RGB);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		send_frame(3, 5);

		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d pixels and %0d palette writes across %0d register settings",
			sb.pixels, sb.palette_writes, mode_changes);
		$display("checked %0d output bytes, %0d mismatches", sb.bytes_checked, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
src/p2y_pkg.sv
src/p2y_ram.sv
src/p2y_front.sv
src/p2y_fifo.sv
src/p2y_back.sv
src/pixel_to_yuv_packer.sv
sim/tb_pixel_to_yuv_packer.sv
